// File: rtl/jsu_pkg.sv
package jsu_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIX,
		ST_STRIP,
		ST_DONE
	} jsu_state_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ONE,
		RES_FINAL
	} jsu_res_sel_t;

	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_POS  = 2'b01;
	localparam logic [1:0] SYM_NEG  = 2'b11;

	typedef struct packed {
		logic         load;
		logic         div_init;
		logic         div_swap;
		logic         div_step;
		logic         fix_init;
		logic         fix_rem;
		logic         strip;
		logic         out_load;
		jsu_res_sel_t res_sel;
	} jsu_cmd_t;

	typedef struct packed {
		logic p_zero;
		logic p_one;
		logic a_zero;
		logic a_even;
		logic div_last;
	} jsu_sts_t;

endpackage

// File: rtl/jsu_dp.sv
module jsu_dp #(
	parameter int WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jsu_pkg::jsu_cmd_t     cmd,
	output jsu_pkg::jsu_sts_t     sts,
	input  logic [WIDTH-1:0]      value,
	input  logic [WIDTH-2:0]      modulus,
	output logic [1:0]            symbol
);
	import jsu_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-2:0] a_q;
	logic [WIDTH-2:0] p_q;
	logic [WIDTH-2:0] r_q;
	logic [WIDTH-1:0] n_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic             sign_q;
	logic [1:0]       sym_q;

	logic [WIDTH-1:0] mag;
	logic [WIDTH-1:0] rs;
	logic [WIDTH-1:0] diff;
	logic             ge;
	logic [WIDTH-2:0] r_next;
	logic [WIDTH-2:0] a_init;
	logic             m8_flip;
	logic             swap_flip;
	logic [1:0]       final_sym;

	// The two's complement negation gives the exact magnitude of the most negative value.
	assign mag       = value[WIDTH-1] ? (~value + 1'b1) : value;
	assign rs        = {r_q, n_q[WIDTH-1]};
	assign diff      = rs - {1'b0, p_q};
	assign ge        = rs >= {1'b0, p_q};
	assign r_next    = ge ? diff[WIDTH-2:0] : rs[WIDTH-2:0];
	assign a_init    = neg_q ? ((r_q == '0) ? '0 : (p_q - r_q)) : r_q;
	assign m8_flip   = p_q[2:0] inside {3'd3, 3'd5};
	assign swap_flip = (a_q[1:0] == 2'd3) && (p_q[1:0] == 2'd3);
	assign final_sym = (p_q == {{(WIDTH-2){1'b0}}, 1'b1}) ? (sign_q ? SYM_NEG : SYM_POS)
		: SYM_ZERO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init || cmd.div_swap) begin
			cnt_q <= CW'(WIDTH);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= mag;
			neg_q  <= value[WIDTH-1];
			p_q    <= modulus;
			sign_q <= 1'b0;
		end
		if (cmd.div_init) begin
			r_q <= '0;
		end
		if (cmd.div_swap) begin
			n_q <= {1'b0, p_q};
			p_q <= a_q;
			a_q <= p_q;
			r_q <= '0;
			if (swap_flip) begin
				sign_q <= ~sign_q;
			end
		end
		if (cmd.div_step) begin
			r_q <= r_next;
			n_q <= {n_q[WIDTH-2:0], 1'b0};
		end
		if (cmd.fix_init) begin
			a_q <= a_init;
		end
		if (cmd.fix_rem) begin
			a_q <= r_q;
		end
		if (cmd.strip) begin
			a_q <= {1'b0, a_q[WIDTH-2:1]};
			if (m8_flip) begin
				sign_q <= ~sign_q;
			end
		end
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_ONE:   sym_q <= SYM_POS;
				RES_FINAL: sym_q <= final_sym;
				default:   sym_q <= SYM_ZERO;
			endcase
		end
	end

	assign sts.p_zero   = (p_q == '0);
	assign sts.p_one    = (p_q == {{(WIDTH-2){1'b0}}, 1'b1});
	assign sts.a_zero   = (a_q == '0);
	assign sts.a_even   = ~a_q[0];
	assign sts.div_last = (cnt_q == CW'(1));
	assign symbol       = sym_q;

endmodule

// File: rtl/jsu_ctrl.sv
module jsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output jsu_pkg::jsu_cmd_t cmd,
	input  jsu_pkg::jsu_sts_t sts
);
	import jsu_pkg::*;

	jsu_state_t   state_q, state_d;
	jsu_res_sel_t res_q, res_d;
	logic         first_q, first_d;
	logic         out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= RES_ZERO;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			first_q     <= first_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		first_d     = first_q;
		out_valid_d = out_valid_q && !m_tready;
		cmd         = '0;
		s_tready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.p_zero) begin
					res_d   = RES_ZERO;
					state_d = ST_DONE;
				end else if (sts.p_one) begin
					res_d   = RES_ONE;
					state_d = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					first_d      = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix_init = first_q;
				cmd.fix_rem  = ~first_q;
				state_d      = ST_STRIP;
			end
			ST_STRIP: begin
				if (sts.a_zero) begin
					res_d   = RES_FINAL;
					state_d = ST_DONE;
				end else if (sts.a_even) begin
					cmd.strip = 1'b1;
				end else begin
					cmd.div_swap = 1'b1;
					first_d      = 1'b0;
					state_d      = ST_DIV;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					cmd.res_sel  = res_q;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	a_load_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CHECK)
		else $error("accepted word did not start evaluation");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && sts.div_last |=> state_q == ST_FIX)
		else $error("division did not end after its last step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside completion");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!m_tvalid || m_tready) |=> state_q == ST_IDLE && m_tvalid)
		else $error("completed result was not handed to the output register");

endmodule

// File: rtl/jacobi_symbol_unit_core.sv
// Sequence: a modulus of zero or one is answered straight from the check state; otherwise each
// reduction is a bit-serial remainder, followed by removing factors of two one at a time.
// Throughput: one word at a time; a new word is taken once the previous result has moved to
// the output register, even while that result waits.
// Reset: arst_n clears the controller and the output valid flag asynchronously.
module jacobi_symbol_unit_core #(
	parameter int WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// value [WIDTH-1:0], modulus [2*WIDTH-2:WIDTH], zero padding above
	input  logic [((2*WIDTH-1+7)/8)*8-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// symbol [1:0], zero padding above
	output logic [7:0]                          m_tdata
);
	import jsu_pkg::*;

	jsu_cmd_t   cmd;
	jsu_sts_t   sts;
	logic [1:0] symbol;

	jsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	jsu_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.value   (s_tdata[WIDTH-1:0]),
		.modulus (s_tdata[2*WIDTH-2:WIDTH]),
		.symbol  (symbol)
	);

	assign m_tdata = {6'b000000, symbol};

endmodule
